// ===== hdl/ivls_pkg.sv =====
// Shared types and constants for the landing-site selector.
`timescale 1ns / 1ps
`default_nettype none
package ivls_pkg;

    localparam int unsigned CNT_W     = 21;
    localparam logic [CNT_W-1:0] PIX_MAX = 21'd1048576;
    localparam int unsigned DIV_STEPS = 24;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_SIDE = 2'd0;
    localparam logic [1:0] CFG_CRUISE    = 2'd1;
    localparam logic [1:0] CFG_RADIUS    = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FIX_SQ,
        OP_FIX_CHK,
        OP_PIX_ADD,
        OP_MUL,
        OP_ACC,
        OP_PREP,
        OP_DIV_STEP,
        OP_FINISH
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        t_op        op;
        logic [1:0] idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
    } t_status;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } t_pt;

endpackage
`default_nettype wire

// ===== hdl/ivls_ctrl.sv =====
// Sequencing state machine of the landing-site selector.
`timescale 1ns / 1ps
`default_nettype none
module ivls_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_mode,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    input  wire ivls_pkg::t_status i_st,
    output ivls_pkg::t_cmd        o_cmd
);
    import ivls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FIXSQ, S_FIXCHK, S_PIX, S_MUL, S_ACC, S_PREP, S_DIV, S_FIN
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       n_valid;
    logic       w_accept;
    logic       w_slot_free;

    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid && (r_state == S_IDLE);
    assign w_slot_free = !o_valid || !i_stall;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_valid       = o_valid && i_stall;
        o_cmd.capture = w_accept;
        o_cmd.op      = OP_NONE;
        o_cmd.idx     = r_cnt[1:0];
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = i_mode ? S_PIX : S_FIXSQ;
                end
            end
            S_FIXSQ: begin
                o_cmd.op = OP_FIX_SQ;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd2) begin
                    n_state = S_FIXCHK;
                end
            end
            S_FIXCHK: begin
                o_cmd.op = OP_FIX_CHK;
                n_state  = S_IDLE;
            end
            S_PIX: begin
                o_cmd.op = OP_PIX_ADD;
                n_state  = i_st.last ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_cnt    = r_cnt + 5'd1;
                n_state  = (r_cnt == 5'd2) ? S_PREP : S_MUL;
            end
            S_PREP: begin
                o_cmd.op = OP_PREP;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    o_cmd.op = OP_FINISH;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            o_valid <= n_valid;
        end
    end

`ifndef SYNTH
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_slot_free) |=> o_valid)
        else $error("finished result not presented");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt != 5'(DIV_STEPS - 1)) |=> (r_state == S_DIV))
        else $error("division left early");
    a_accept_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_FIXSQ || r_state == S_PIX))
        else $error("accepted transfer not processed");
`endif

endmodule
`default_nettype wire

// ===== hdl/ivls_dp.sv =====
// Datapath: position tracking, pixel statistics, variance divider and route.
`timescale 1ns / 1ps
`default_nettype none
module ivls_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ivls_pkg::t_cmd     i_cmd,
    output ivls_pkg::t_status       o_st,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [39:0]        i_cfg_data,
    input  wire logic               i_mode,
    input  wire logic signed [23:0] i_pos_x,
    input  wire logic signed [23:0] i_pos_y,
    input  wire logic signed [23:0] i_pos_z,
    input  wire logic [7:0]         i_red,
    input  wire logic [7:0]         i_green,
    input  wire logic [7:0]         i_blue,
    input  wire logic               i_last_pixel,
    output logic [23:0]             o_total_variance,
    output logic [23:0]             o_best_variance,
    output logic                    o_new_waypoint,
    output logic signed [23:0]      o_wp_x,
    output logic signed [23:0]      o_wp_y,
    output logic signed [23:0]      o_wp_z,
    output logic [2:0]              o_wp_number
);
    import ivls_pkg::*;

    function automatic t_pt wp_point(input logic [2:0] k, input logic [22:0] h,
                                     input logic [22:0] a, input logic signed [23:0] lx,
                                     input logic signed [23:0] ly);
        t_pt p;
        logic signed [23:0] hp, hn, az;
        hp = $signed({1'b0, h});
        hn = -hp;
        az = $signed({1'b0, a});
        case (k)
            3'd0:    p = '{x: hp, y: hp, z: az};
            3'd1:    p = '{x: hn, y: hp, z: az};
            3'd2:    p = '{x: hn, y: hn, z: az};
            3'd3:    p = '{x: hp, y: hn, z: az};
            3'd4:    p = '{x: lx, y: ly, z: az};
            default: p = '{x: lx, y: ly, z: 24'sd0};
        endcase
        return p;
    endfunction

    // configuration
    logic [22:0] r_half, r_cruise;
    logic [39:0] r_radius;
    // captured item
    logic [7:0]  r_pix [3];
    logic        r_last;
    // tracking state
    logic signed [23:0] r_cur_x, r_cur_y, r_cur_z;
    logic signed [23:0] r_best_x, r_best_y, r_land_x, r_land_y;
    logic [23:0] r_min;
    logic [2:0]  r_issued;
    logic        r_reached;
    logic [49:0] r_d2;
    // statistics
    logic [CNT_W-1:0] r_count;
    logic [27:0] r_sum [3];
    logic [35:0] r_sq [3];
    logic [56:0] r_p1;
    logic [55:0] r_p2;
    logic [57:0] r_num;
    logic [40:0] r_n2;
    logic [40:0] r_rem;
    logic [23:0] r_dlow;
    logic [23:0] r_q;

    assign o_st.last = r_last;

    // reach distance, one axis per step
    t_pt                w_tgt;
    logic signed [23:0] w_ca, w_ct;
    logic signed [24:0] w_diff, w_abs;
    logic [23:0]        w_mag;
    logic [47:0]        w_sqd;
    always_comb begin
        w_tgt = wp_point(r_issued - 3'd1, r_half, r_cruise, r_land_x, r_land_y);
        case (i_cmd.idx)
            2'd0:    begin w_ca = r_cur_x; w_ct = w_tgt.x; end
            2'd1:    begin w_ca = r_cur_y; w_ct = w_tgt.y; end
            default: begin w_ca = r_cur_z; w_ct = w_tgt.z; end
        endcase
        w_diff = {w_ca[23], w_ca} - {w_ct[23], w_ct};
        w_abs  = w_diff[24] ? -w_diff : w_diff;
        w_mag  = w_abs[23:0];
        w_sqd  = w_mag * w_mag;
    end

    // variance helpers
    logic [CNT_W-1:0] w_n;
    logic [56:0]      w_term;
    logic [41:0]      w_t;
    logic             w_ge;
    assign w_n    = (r_count == '0) ? CNT_W'(1) : r_count;
    assign w_term = r_p1 - {1'b0, r_p2};
    assign w_t    = {r_rem, r_dlow[23]};
    assign w_ge   = (w_t >= {1'b0, r_n2});

    // image end: best site and next waypoint
    logic               w_better, w_issue;
    logic signed [23:0] w_nbx, w_nby, w_lx, w_ly;
    t_pt                w_wp;
    always_comb begin
        w_better = (r_q < r_min);
        w_nbx    = w_better ? r_cur_x : r_best_x;
        w_nby    = w_better ? r_cur_y : r_best_y;
        w_issue  = r_reached && (r_issued < 3'd6);
        w_lx     = (r_issued == 3'd4) ? w_nbx : r_land_x;
        w_ly     = (r_issued == 3'd4) ? w_nby : r_land_y;
        w_wp     = wp_point(r_issued, r_half, r_cruise, w_lx, w_ly);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half   <= 23'd5120;
            r_cruise <= 23'd2560;
            r_radius <= 40'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALF_SIDE: r_half   <= i_cfg_data[22:0];
                CFG_CRUISE:    r_cruise <= i_cfg_data[22:0];
                CFG_RADIUS:    r_radius <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // captured pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix[0] <= i_red;
            r_pix[1] <= i_green;
            r_pix[2] <= i_blue;
            r_last   <= i_last_pixel;
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_FIX_SQ: r_d2 <= (i_cmd.idx == 2'd0) ? {2'b0, w_sqd} : r_d2 + {2'b0, w_sqd};
            OP_MUL: begin
                r_p1 <= 57'(w_n * r_sq[i_cmd.idx]);
                r_p2 <= 56'(r_sum[i_cmd.idx] * r_sum[i_cmd.idx]);
            end
            OP_ACC: r_num <= (i_cmd.idx == 2'd0) ? {1'b0, w_term} : r_num + {1'b0, w_term};
            OP_PREP: begin
                r_n2   <= 41'(w_n * w_n);
                r_rem  <= r_num[56:16];
                r_dlow <= {r_num[15:0], 8'h00};
                r_q    <= '0;
            end
            OP_DIV_STEP: begin
                r_rem  <= w_ge ? 41'(w_t - {1'b0, r_n2}) : w_t[40:0];
                r_dlow <= {r_dlow[22:0], 1'b0};
                r_q    <= {r_q[22:0], w_ge};
            end
            default: ;
        endcase
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_cur_z   <= '0;
            r_best_x  <= '0;
            r_best_y  <= '0;
            r_land_x  <= '0;
            r_land_y  <= '0;
            r_min     <= '1;
            r_issued  <= '0;
            r_reached <= 1'b1;
            r_count   <= '0;
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
                r_sq[c]  <= '0;
            end
        end else begin
            if (i_cmd.capture && !i_mode) begin
                r_cur_x <= i_pos_x;
                r_cur_y <= i_pos_y;
                r_cur_z <= i_pos_z;
            end
            case (i_cmd.op)
                OP_FIX_CHK: begin
                    if (!r_reached && r_issued != 3'd0 && r_issued <= 3'd6
                        && r_d2 < {10'b0, r_radius}) begin
                        r_reached <= 1'b1;
                    end
                end
                OP_PIX_ADD: begin
                    if (r_count < PIX_MAX) begin
                        for (int c = 0; c < 3; c++) begin
                            r_sum[c] <= r_sum[c] + {20'b0, r_pix[c]};
                            r_sq[c]  <= r_sq[c] + {20'b0, 16'(r_pix[c] * r_pix[c])};
                        end
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                OP_FINISH: begin
                    r_count <= '0;
                    for (int c = 0; c < 3; c++) begin
                        r_sum[c] <= '0;
                        r_sq[c]  <= '0;
                    end
                    if (w_better) begin
                        r_min    <= r_q;
                        r_best_x <= r_cur_x;
                        r_best_y <= r_cur_y;
                    end
                    if (w_issue) begin
                        r_land_x  <= w_lx;
                        r_land_y  <= w_ly;
                        r_issued  <= r_issued + 3'd1;
                        r_reached <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FINISH) begin
            o_total_variance <= r_q;
            o_best_variance  <= w_better ? r_q : r_min;
            o_new_waypoint   <= w_issue;
            o_wp_x           <= w_issue ? w_wp.x : 24'sd0;
            o_wp_y           <= w_issue ? w_wp.y : 24'sd0;
            o_wp_z           <= w_issue ? w_wp.z : 24'sd0;
            o_wp_number      <= w_issue ? r_issued : 3'd0;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/image_variance_landing_site_selector_top.sv =====
// Top level of the image variance landing-site selector.
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_stall  i_mode, i_pos_*, i_red/green/blue, i_last_pixel
//  result    out        o_valid / i_stall  o_total_variance .. o_wp_number
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// A position fix forms three squared axis distances, then one compare.
// A pixel is added to the channel sums; the last pixel of an image then runs a multiply and
// accumulate per channel, the divider preparation, the 24-step restoring divider that forms the
// Q8 variance, and the finish. Reset is synchronous, active low, and restores the register defaults.
// A held result does not block new input; only image end waits for the result slot.
`timescale 1ns / 1ps
`default_nettype none
module image_variance_landing_site_selector_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_mode,
    input  wire logic signed [23:0] i_pos_x,
    input  wire logic signed [23:0] i_pos_y,
    input  wire logic signed [23:0] i_pos_z,
    input  wire logic [7:0]         i_red,
    input  wire logic [7:0]         i_green,
    input  wire logic [7:0]         i_blue,
    input  wire logic               i_last_pixel,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [23:0]             o_total_variance,
    output logic [23:0]             o_best_variance,
    output logic                    o_new_waypoint,
    output logic signed [23:0]      o_wp_x,
    output logic signed [23:0]      o_wp_y,
    output logic signed [23:0]      o_wp_z,
    output logic [2:0]              o_wp_number,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [39:0]        i_cfg_data
);
    import ivls_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    // sequencer
    ivls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    // datapath
    ivls_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_st             (w_st),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_last_pixel     (i_last_pixel),
        .o_total_variance (o_total_variance),
        .o_best_variance  (o_best_variance),
        .o_new_waypoint   (o_new_waypoint),
        .o_wp_x           (o_wp_x),
        .o_wp_y           (o_wp_y),
        .o_wp_z           (o_wp_z),
        .o_wp_number      (o_wp_number)
    );

endmodule
`default_nettype wire
